[hw/rtl/box_table_collision_classifier_top_macros.svh]
// assertion macros for the box table collision classifier
// used by the port checker; no other dependencies
`ifndef BOX_TABLE_COLLISION_CLASSIFIER_TOP_MACROS_SVH
`define BOX_TABLE_COLLISION_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BTCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("btcc check failed: same cycle");

// next-cycle implication, disabled during reset
`define BTCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("btcc check failed: next cycle");

`endif

[hw/rtl/btcc_pkg.sv]
// shared types and constants for the box table collision classifier
// no dependencies
package btcc_pkg;

  localparam int unsigned MAX_BOXES = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned SUM_W     = 18;

  localparam logic signed [SUM_W-1:0] GROUND_MARGIN = 18'sd5;

  // request command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // test slots in the result accumulators
  localparam int unsigned T_FLOOR     = 0;
  localparam int unsigned T_STRICT    = 1;
  localparam int unsigned T_CEILING   = 2;
  localparam int unsigned T_LEFT      = 3;
  localparam int unsigned T_RIGHT     = 4;
  localparam int unsigned NUM_TESTS   = 5;

  typedef struct packed {
    logic        [14:0] h;
    logic        [14:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } box_t;

endpackage

[hw/rtl/box_table_collision_classifier_top.sv]
// box table collision classifier, top level
// depends on btcc_pkg
//   request channel (in_valid_i / in_stall_o): cmd_i loads a box into slot_i or
//   queries the entity box against slots 0 .. box_count-1 in order
//   result channel (out_valid_o / out_stall_i): one result per query with the
//   hit flag and first matching slot of each test plus the inside flag; a load
//   gives no result
//   box_count is written through cfg_we_i / cfg_wdata_i while the block is idle;
//   counts above 64 scan 64 slots
//   a load writes its slot as it is taken and the next request is taken right after it
//   a query scans the capped count of slots, one table read per cycle; each read
//   is registered in rd_box_q, its tests update the running results, and the
//   closed scan loads the output register once it is free; the next request
//   can be taken in the cycle in which the result appears
//   reset clears the controller, box_count and the output valid; the box
//   memory is not cleared, so a slot must be loaded before a query scans it
//   a stalled result sits in the output register while loads are still taken;
//   a finished query waits until the output register frees, stalling input
module box_table_collision_classifier_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [6:0]              cfg_wdata_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic [5:0]              slot_i,
  input  logic signed [15:0]      pos_x_i,
  input  logic signed [15:0]      pos_y_i,
  input  logic [14:0]             box_width_i,
  input  logic [14:0]             box_height_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    floor_hit_o,
  output logic [5:0]              floor_index_o,
  output logic                    strict_floor_hit_o,
  output logic [5:0]              strict_floor_index_o,
  output logic                    ceiling_hit_o,
  output logic [5:0]              ceiling_index_o,
  output logic                    left_wall_hit_o,
  output logic [5:0]              left_wall_index_o,
  output logic                    right_wall_hit_o,
  output logic [5:0]              right_wall_index_o,
  output logic                    inside_any_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  localparam int unsigned ADDR_W = btcc_pkg::ADDR_W;
  localparam int unsigned CNT_W  = btcc_pkg::CNT_W;
  localparam int unsigned IDX_W  = btcc_pkg::IDX_W;
  localparam int unsigned SUM_W  = btcc_pkg::SUM_W;
  localparam int unsigned NT     = btcc_pkg::NUM_TESTS;

  state_e state_q, state_d;

  logic [6:0]        box_count_q;
  logic [CNT_W-1:0]  issue_cnt_q, issue_cnt_d;
  logic [CNT_W-1:0]  scan_len_q, scan_len_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0] rd_idx_q;

  logic              in_accept;
  logic              query_accept;
  logic              load_accept;
  logic              issue;
  logic              scan_done;
  logic              out_free;
  logic              hand_over;

  // box table, one read or one write per cycle
  btcc_pkg::box_t    box_mem [btcc_pkg::MAX_BOXES];
  btcc_pkg::box_t    rd_box_q;
  btcc_pkg::box_t    wr_box;

  // entity terms, precomputed at query accept
  logic signed [SUM_W-1:0] ex_q, ey_q, er_q, eb_q, er_m5_q, ex_p5_q;

  // running results of the scan
  logic [NT-1:0]     acc_hit_q;
  logic [IDX_W-1:0]  acc_idx_q [NT];
  logic              acc_inside_q;

  // tests of the box that is being evaluated
  logic signed [SUM_W-1:0] bx, by, br, bb;
  logic [NT-1:0]     test_hit;
  logic              test_inside;

  // output register
  logic [NT-1:0]     out_hit_q;
  logic [IDX_W-1:0]  out_idx_q [NT];
  logic              out_inside_q;
  logic              out_valid_q, out_valid_d;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign query_accept = in_accept && (cmd_i == btcc_pkg::CMD_QUERY);
  assign load_accept  = in_accept && (cmd_i == btcc_pkg::CMD_LOAD);

  // one read issued per cycle until the capped count is reached
  assign issue     = (state_q == ST_SCAN) && (issue_cnt_q < scan_len_q);
  assign scan_done = (state_q == ST_SCAN) && !issue && !rd_vld_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign hand_over = (state_q == ST_HOLD) && out_free;

  assign wr_box = '{h: box_height_i, w: box_width_i, y: pos_y_i, x: pos_x_i};

  // box memory, synchronous read into rd_box_q
  always_ff @(posedge clk_i) begin
    if (load_accept) begin
      box_mem[slot_i[ADDR_W-1:0]] <= wr_box;
    end
    if (issue) begin
      rd_box_q <= box_mem[issue_cnt_q[ADDR_W-1:0]];
    end
  end

  // box geometry, all sums at 18 bits so nothing wraps
  always_comb begin
    bx = SUM_W'(rd_box_q.x);
    by = SUM_W'(rd_box_q.y);
    br = bx + $signed({{(SUM_W-15){1'b0}}, rd_box_q.w});
    bb = by + $signed({{(SUM_W-15){1'b0}}, rd_box_q.h});

    // ground with side margins and one pixel of bottom slack
    test_hit[btcc_pkg::T_FLOOR]   = (er_m5_q >= bx) && (ex_p5_q <= br) &&
                                    (eb_q >= by) && (eb_q < bb);
    test_hit[btcc_pkg::T_STRICT]  = (er_q > bx) && (ex_q < br) &&
                                    (eb_q > by) && (eb_q < bb);
    test_hit[btcc_pkg::T_CEILING] = (er_q > bx) && (ex_q < br) &&
                                    (ey_q < bb) && (ey_q > by);
    test_hit[btcc_pkg::T_LEFT]    = (eb_q > by) && (ey_q < bb) &&
                                    (er_q > bx) && (ex_q < bx);
    test_hit[btcc_pkg::T_RIGHT]   = (eb_q > by) && (ey_q < bb) &&
                                    (ex_q < br) && (er_q > br);
    test_inside = (ey_q >= by) && (eb_q <= bb) && (ex_q >= bx) && (er_q <= br);
  end

  // entity terms and scan accumulators, no reset needed
  always_ff @(posedge clk_i) begin
    if (query_accept) begin
      ex_q    <= SUM_W'(pos_x_i);
      ey_q    <= SUM_W'(pos_y_i);
      er_q    <= SUM_W'(pos_x_i) + $signed({{(SUM_W-15){1'b0}}, box_width_i});
      eb_q    <= SUM_W'(pos_y_i) + $signed({{(SUM_W-15){1'b0}}, box_height_i});
      er_m5_q <= SUM_W'(pos_x_i) + $signed({{(SUM_W-15){1'b0}}, box_width_i})
                 - btcc_pkg::GROUND_MARGIN;
      ex_p5_q <= SUM_W'(pos_x_i) + btcc_pkg::GROUND_MARGIN;
      acc_hit_q    <= '0;
      acc_inside_q <= 1'b0;
      for (int t = 0; t < NT; t++) begin
        acc_idx_q[t] <= '0;
      end
    end else if (rd_vld_q) begin
      // first matching slot wins
      for (int t = 0; t < NT; t++) begin
        if (test_hit[t] && !acc_hit_q[t]) begin
          acc_hit_q[t] <= 1'b1;
          acc_idx_q[t] <= IDX_W'(rd_idx_q);
        end
      end
      if (test_inside) begin
        acc_inside_q <= 1'b1;
      end
    end
    if (issue) begin
      rd_idx_q <= issue_cnt_q[ADDR_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    scan_len_d  = scan_len_q;
    rd_vld_d    = issue;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (query_accept) begin
          state_d     = ST_SCAN;
          issue_cnt_d = '0;
          scan_len_d  = (box_count_q > 7'(btcc_pkg::MAX_BOXES)) ?
                        CNT_W'(btcc_pkg::MAX_BOXES) : CNT_W'(box_count_q);
        end
      end
      ST_SCAN: begin
        if (issue) begin
          issue_cnt_d = issue_cnt_q + 1'b1;
        end
        if (scan_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (hand_over) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      box_count_q  <= '0;
      issue_cnt_q  <= '0;
      scan_len_q   <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= '0;
      out_inside_q <= 1'b0;
      for (int t = 0; t < NT; t++) begin
        out_idx_q[t] <= '0;
      end
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      scan_len_q  <= scan_len_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        box_count_q <= cfg_wdata_i;
      end
      if (hand_over) begin
        out_hit_q    <= acc_hit_q;
        out_inside_q <= acc_inside_q;
        for (int t = 0; t < NT; t++) begin
          out_idx_q[t] <= acc_idx_q[t];
        end
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign floor_hit_o          = out_hit_q[btcc_pkg::T_FLOOR];
  assign floor_index_o        = out_idx_q[btcc_pkg::T_FLOOR];
  assign strict_floor_hit_o   = out_hit_q[btcc_pkg::T_STRICT];
  assign strict_floor_index_o = out_idx_q[btcc_pkg::T_STRICT];
  assign ceiling_hit_o        = out_hit_q[btcc_pkg::T_CEILING];
  assign ceiling_index_o      = out_idx_q[btcc_pkg::T_CEILING];
  assign left_wall_hit_o      = out_hit_q[btcc_pkg::T_LEFT];
  assign left_wall_index_o    = out_idx_q[btcc_pkg::T_LEFT];
  assign right_wall_hit_o     = out_hit_q[btcc_pkg::T_RIGHT];
  assign right_wall_index_o   = out_idx_q[btcc_pkg::T_RIGHT];
  assign inside_any_o         = out_inside_q;

endmodule

[hw/rtl/btcc_checker.sv]
// port-level checks for the box table collision classifier
// depends on btcc_pkg and box_table_collision_classifier_top_macros.svh
`include "box_table_collision_classifier_top_macros.svh"

module btcc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              cmd_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              floor_hit_o,
  input logic [5:0]        floor_index_o,
  input logic              strict_floor_hit_o,
  input logic [5:0]        strict_floor_index_o,
  input logic              ceiling_hit_o,
  input logic [5:0]        ceiling_index_o,
  input logic              left_wall_hit_o,
  input logic [5:0]        left_wall_index_o,
  input logic              right_wall_hit_o,
  input logic [5:0]        right_wall_index_o,
  input logic              inside_any_o
);

  logic query_acc;
  logic load_acc;
  logic idx_clean;
  logic [35:0] out_word;

  assign query_acc = in_valid_i && !in_stall_o && (cmd_i == btcc_pkg::CMD_QUERY);
  assign load_acc  = in_valid_i && !in_stall_o && (cmd_i == btcc_pkg::CMD_LOAD);

  assign out_word = {floor_hit_o, floor_index_o, strict_floor_hit_o, strict_floor_index_o,
                     ceiling_hit_o, ceiling_index_o, left_wall_hit_o, left_wall_index_o,
                     right_wall_hit_o, right_wall_index_o, inside_any_o};

  // an index without its hit flag must read zero
  assign idx_clean = (floor_hit_o || (floor_index_o == '0)) &&
                     (strict_floor_hit_o || (strict_floor_index_o == '0)) &&
                     (ceiling_hit_o || (ceiling_index_o == '0)) &&
                     (left_wall_hit_o || (left_wall_index_o == '0)) &&
                     (right_wall_hit_o || (right_wall_index_o == '0));

  // a stalled result holds
  `BTCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))
  // a query keeps the input stalled in the cycle after it is accepted
  `BTCC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_acc, in_stall_o)
  // a load never creates a result
  `BTCC_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, load_acc && !out_valid_o, !out_valid_o)
  // unmatched tests report slot zero
  `BTCC_ASSERT_NOW(a_idx_clean, clk_i, rst_ni, out_valid_o, idx_clean)

endmodule

bind box_table_collision_classifier_top btcc_checker u_btcc_checker (.*);

[bench/contact_check_pkg.sv]
`timescale 1ns / 100ps
// request/result types and the scoreboard for the box table collision classifier bench
// depends on btcc_pkg for box_t, command codes and table size
package contact_check_pkg;
  import btcc_pkg::*;

  localparam int FLOOR_MARGIN = 5;
  localparam int FLOOR_SLACK  = 1;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } request_t;

  typedef struct packed {
    logic             floor_hit;
    logic [IDX_W-1:0] floor_index;
    logic             strict_hit;
    logic [IDX_W-1:0] strict_index;
    logic             ceiling_hit;
    logic [IDX_W-1:0] ceiling_index;
    logic             left_hit;
    logic [IDX_W-1:0] left_index;
    logic             right_hit;
    logic [IDX_W-1:0] right_index;
    logic             inside_any;
  } contact_result_t;

  class contact_scoreboard;
    box_t            box_table [MAX_BOXES];
    int unsigned     box_count;
    contact_result_t pending_contacts [$];
    int unsigned     mismatches;
    int unsigned     loads_seen;
    int unsigned     queries_seen;
    int unsigned     hits [6];

    function void set_box_count(logic [6:0] value);
      box_count = value;
    endfunction

    function int pending();
      return pending_contacts.size();
    endfunction

    // expected contacts of an entity against the scanned part of the table
    function contact_result_t predict_contacts(request_t q);
      contact_result_t res;
      int ex, ey, er, eb, bx, by, br, bb, n;
      res = '0;
      ex  = $signed(q.x);
      ey  = $signed(q.y);
      er  = q.w;
      eb  = q.h;
      er  = ex + er;
      eb  = ey + eb;
      n   = (box_count > MAX_BOXES) ? MAX_BOXES : box_count;
      for (int i = 0; i < n; i++) begin
        bx = $signed(box_table[i].x);
        by = $signed(box_table[i].y);
        br = box_table[i].w;
        bb = box_table[i].h;
        br = bx + br;
        bb = by + bb;
        if (!res.floor_hit && er - FLOOR_MARGIN >= bx && ex + FLOOR_MARGIN <= br &&
            eb >= by && eb <= bb - FLOOR_SLACK) begin
          res.floor_hit   = 1'b1;
          res.floor_index = IDX_W'(i);
        end
        if (!res.strict_hit && er > bx && ex < br && eb > by && eb < bb) begin
          res.strict_hit   = 1'b1;
          res.strict_index = IDX_W'(i);
        end
        if (!res.ceiling_hit && er > bx && ex < br && ey < bb && ey > by) begin
          res.ceiling_hit   = 1'b1;
          res.ceiling_index = IDX_W'(i);
        end
        if (!res.left_hit && eb > by && ey < bb && er > bx && ex < bx) begin
          res.left_hit   = 1'b1;
          res.left_index = IDX_W'(i);
        end
        if (!res.right_hit && eb > by && ey < bb && ex < br && er > br) begin
          res.right_hit   = 1'b1;
          res.right_index = IDX_W'(i);
        end
        if (ey >= by && eb <= bb && ex >= bx && er <= br) begin
          res.inside_any = 1'b1;
        end
      end
      return res;
    endfunction

    function void note_request(request_t r);
      contact_result_t res;
      if (r.cmd == CMD_LOAD) begin
        box_table[r.slot] = '{h: r.h, w: r.w, y: r.y, x: r.x};
        loads_seen++;
      end else begin
        res = predict_contacts(r);
        pending_contacts.push_back(res);
        queries_seen++;
        hits[0] += res.floor_hit;
        hits[1] += res.strict_hit;
        hits[2] += res.ceiling_hit;
        hits[3] += res.left_hit;
        hits[4] += res.right_hit;
        hits[5] += res.inside_any;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(contact_result_t got);
      contact_result_t want;
      if (pending_contacts.size() == 0) begin
        $error("result with no query outstanding");
        mismatches++;
        return;
      end
      want = pending_contacts.pop_front();
      compare_field("floor_hit", want.floor_hit, got.floor_hit);
      compare_field("floor_index", want.floor_index, got.floor_index);
      compare_field("strict_floor_hit", want.strict_hit, got.strict_hit);
      compare_field("strict_floor_index", want.strict_index, got.strict_index);
      compare_field("ceiling_hit", want.ceiling_hit, got.ceiling_hit);
      compare_field("ceiling_index", want.ceiling_index, got.ceiling_index);
      compare_field("left_wall_hit", want.left_hit, got.left_hit);
      compare_field("left_wall_index", want.left_index, got.left_index);
      compare_field("right_wall_hit", want.right_hit, got.right_hit);
      compare_field("right_wall_index", want.right_index, got.right_index);
      compare_field("inside_any", want.inside_any, got.inside_any);
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// top-level bench for box_table_collision_classifier_top: directed and random
// load/query requests checked against contact_check_pkg's scoreboard
// depends on btcc_pkg and contact_check_pkg
module tb_top;
  import btcc_pkg::*;
  import contact_check_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 40;
  localparam int SETTLE       = 8;        // a load leaves the block idle
  localparam int TAIL_CYCLES  = 80;       // covers the longest query, a full 64-slot scan
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 500000;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [6:0]         cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               cmd_i        = CMD_LOAD;
  logic [5:0]         slot_i       = '0;
  logic signed [15:0] pos_x_i      = '0;
  logic signed [15:0] pos_y_i      = '0;
  logic [14:0]        box_width_i  = '0;
  logic [14:0]        box_height_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               floor_hit_o;
  logic [5:0]         floor_index_o;
  logic               strict_floor_hit_o;
  logic [5:0]         strict_floor_index_o;
  logic               ceiling_hit_o;
  logic [5:0]         ceiling_index_o;
  logic               left_wall_hit_o;
  logic [5:0]         left_wall_index_o;
  logic               right_wall_hit_o;
  logic [5:0]         right_wall_index_o;
  logic               inside_any_o;

  contact_scoreboard sb;

  // shared knobs between the sender and the receiver
  logic        no_idle       = 1'b0;   // both sides run flat out
  int unsigned hold_requests = 0;      // bumped by the sender to ask for a long hold-off
  int unsigned holds_served  = 0;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned settings_used = 0;
  contact_result_t observed;

  box_table_collision_classifier_top uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cmd_i                (cmd_i),
    .slot_i               (slot_i),
    .pos_x_i              (pos_x_i),
    .pos_y_i              (pos_y_i),
    .box_width_i          (box_width_i),
    .box_height_i         (box_height_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .floor_hit_o          (floor_hit_o),
    .floor_index_o        (floor_index_o),
    .strict_floor_hit_o   (strict_floor_hit_o),
    .strict_floor_index_o (strict_floor_index_o),
    .ceiling_hit_o        (ceiling_hit_o),
    .ceiling_index_o      (ceiling_index_o),
    .left_wall_hit_o      (left_wall_hit_o),
    .left_wall_index_o    (left_wall_index_o),
    .right_wall_hit_o     (right_wall_hit_o),
    .right_wall_index_o   (right_wall_index_o),
    .inside_any_o         (inside_any_o)
  );

  always #6 clk_i = ~clk_i;

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check what was taken at this edge, then pick the next stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      observed = '{floor_hit: floor_hit_o, floor_index: floor_index_o,
                   strict_hit: strict_floor_hit_o, strict_index: strict_floor_index_o,
                   ceiling_hit: ceiling_hit_o, ceiling_index: ceiling_index_o,
                   left_hit: left_wall_hit_o, left_index: left_wall_index_o,
                   right_hit: right_wall_hit_o, right_index: right_wall_index_o,
                   inside_any: inside_any_o};
      sb.check_result(observed);
    end
    // a long hold-off lets the block back up into its input
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      stall_left   = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 31);
    end
  end

  // offer one request and hold it until taken, then maybe leave a gap
  task automatic issue_request(input logic cmd, input logic [5:0] slot,
                               input int x, input int y, input int w, input int h);
    request_t r;
    int unsigned gaps;
    r = '{cmd: cmd, slot: slot, x: 16'(x), y: 16'(y), w: 15'(w), h: 15'(h)};
    in_valid_i   <= 1'b1;
    cmd_i        <= r.cmd;
    slot_i       <= r.slot;
    pos_x_i      <= r.x;
    pos_y_i      <= r.y;
    box_width_i  <= r.w;
    box_height_i <= r.h;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    gaps = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 31) gaps++;
    end
    if (gaps != 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every query has answered and loads have settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // box_count is only touched while the block is idle
  task automatic write_count(input logic [6:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_box_count(value);
    settings_used++;
  endtask

  // boxes of a small world near the origin, so that queries collide often
  task automatic load_world_box(input logic [5:0] slot);
    issue_request(CMD_LOAD, slot, int'($urandom_range(800)) - 400,
                  int'($urandom_range(800)) - 400, $urandom_range(120), $urandom_range(120));
  endtask

  initial begin
    int box_counts [PHASES];
    int eff, target, bx, by, bw, bh, ex, ey, ew, eh, roll;
    sb = new();
    box_counts = '{64, 127, 1, 65, 0, 0, 0, 0, 40, 2};
    for (int p = 5; p < 8; p++) box_counts[p] = $urandom_range(64, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero count: every flag and index stays clear
    write_count(7'd0);
    issue_request(CMD_QUERY, 6'd17, 0, 0, 10, 10);

    // hand-made table
    issue_request(CMD_LOAD, 6'd0, 0, 100, 200, 20);              // floor slab
    issue_request(CMD_LOAD, 6'd1, 300, 0, 20, 200);              // tall wall
    issue_request(CMD_LOAD, 6'd2, -100, -50, 250, 40);           // ceiling slab
    issue_request(CMD_LOAD, 6'd3, -32768, -32768, 32767, 32767); // most negative corner
    issue_request(CMD_LOAD, 6'd4, 32767, 32767, 32767, 32767);   // most positive corner
    issue_request(CMD_LOAD, 6'd5, 50, 50, 0, 0);                 // zero-size box
    write_count(7'd6);

    issue_request(CMD_QUERY, 6'd63, 10, 80, 20, 20);    // resting on top: margined only
    issue_request(CMD_QUERY, 6'd0, 10, 81, 20, 20);     // sunk one pixel: strict too
    issue_request(CMD_QUERY, 6'd42, 10, 99, 20, 20);    // bottom at the slack limit
    issue_request(CMD_QUERY, 6'd21, 10, 100, 20, 20);   // bottom on slab bottom edge
    issue_request(CMD_QUERY, 6'd5, -25, 81, 30, 20);    // right on the side margin
    issue_request(CMD_QUERY, 6'd9, -26, 81, 30, 20);    // one past the margin, left wall
    issue_request(CMD_QUERY, 6'd33, 110, -20, 10, 30);  // head inside the ceiling slab
    issue_request(CMD_QUERY, 6'd1, 290, 50, 20, 20);    // left side of the wall
    issue_request(CMD_QUERY, 6'd2, 310, 50, 20, 20);    // right side of the wall
    issue_request(CMD_QUERY, 6'd3, 305, 10, 10, 10);    // wholly inside the wall
    issue_request(CMD_QUERY, 6'd4, 0, 100, 200, 20);    // same box as the slab
    issue_request(CMD_QUERY, 6'd7, 32767, 32767, 32767, 32767);
    issue_request(CMD_QUERY, 6'd8, -32768, -32768, 0, 0);
    issue_request(CMD_QUERY, 6'd60, -1, -1, 32767, 32767);

    // fill the rest of the table so every count is legal from here on
    for (int s = 6; s < MAX_BOXES; s++) load_world_box(6'(s));

    for (int phase = 0; phase < PHASES; phase++) begin
      write_count(7'(box_counts[phase]));
      no_idle <= (phase == 1);
      eff = (box_counts[phase] > MAX_BOXES) ? MAX_BOXES : box_counts[phase];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == 8) hold_requests <= hold_requests + 1;
        if (phase == 6 && k == 20) wait_idle();
        roll = $urandom_range(99);
        if (roll < 12) begin
          // full-range noise, load or query
          issue_request(1'($urandom_range(1)), 6'($urandom_range(63)), $urandom,
                        $urandom, $urandom, $urandom);
        end else if (roll < 35) begin
          load_world_box(6'($urandom_range(63)));
        end else begin
          // entity placed around a stored box, edges straddling its borders
          target = $urandom_range((eff == 0) ? MAX_BOXES - 1 : eff - 1);
          bx = $signed(sb.box_table[target].x);
          by = $signed(sb.box_table[target].y);
          bw = sb.box_table[target].w;
          bh = sb.box_table[target].h;
          ew = $urandom_range(40);
          eh = $urandom_range(40);
          ex = bx + int'($urandom_range(bw + ew + 12)) - ew - 6;
          ey = by + int'($urandom_range(bh + eh + 12)) - eh - 6;
          case ($urandom_range(5))
            0: ey = by - eh;            // standing exactly on top
            1: ey = by + bh - 1 - eh;   // bottom on the slack limit
            2: ex = bx - ew + 5;        // right on the ground margin
            default: ;
          endcase
          issue_request(CMD_QUERY, 6'($urandom_range(63)), ex, ey, ew, eh);
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d loads and %0d queries over %0d box_count settings",
             sb.loads_seen, sb.queries_seen, settings_used);
    $display("hits: floor %0d strict %0d ceiling %0d left %0d right %0d inside %0d",
             sb.hits[0], sb.hits[1], sb.hits[2], sb.hits[3], sb.hits[4], sb.hits[5]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/btcc_pkg.sv
hw/rtl/box_table_collision_classifier_top.sv
hw/rtl/btcc_checker.sv
bench/contact_check_pkg.sv
bench/tb_top.sv
